/* rtl/sdo_wrs_pkg.sv */
// Shared types, codes and field widths for the SDO write retry sequencer.
`default_nettype none

package sdo_wrs_pkg;

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 72;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_TIMEOUT_TICKS    = 3'd0;
  localparam cfg_idx_t REG_MAX_RETRIES      = 3'd1;
  localparam cfg_idx_t REG_REQUEST_INDEX    = 3'd2;
  localparam cfg_idx_t REG_REQUEST_SUBINDEX = 3'd3;
  localparam cfg_idx_t REG_REQUEST_DATA     = 3'd4;

  // Register reset values
  localparam logic [15:0] RST_TIMEOUT_TICKS    = 16'd100;
  localparam logic [3:0]  RST_MAX_RETRIES      = 4'd2;
  localparam logic [15:0] RST_REQUEST_INDEX    = 16'h6200;
  localparam logic [7:0]  RST_REQUEST_SUBINDEX = 8'h00;
  localparam logic [31:0] RST_REQUEST_DATA     = 32'h0000_0032;

  // SDO command bytes
  localparam logic [7:0] CMD_WRITE_4   = 8'h2B;
  localparam logic [7:0] CMD_ANSWER_OK = 8'h60;

  localparam logic [15:0] TIMER_MAX = 16'hFFFF;

  // Phase codes as reported on the result stream
  localparam logic [2:0] PH_CODE_WAIT   = 3'd0;
  localparam logic [2:0] PH_CODE_SEND   = 3'd1;
  localparam logic [2:0] PH_CODE_AWAIT  = 3'd2;
  localparam logic [2:0] PH_CODE_DONE   = 3'd3;
  localparam logic [2:0] PH_CODE_FAILED = 3'd4;

  typedef enum logic [4:0] {
    PH_WAIT   = 5'b00001,
    PH_SEND   = 5'b00010,
    PH_AWAIT  = 5'b00100,
    PH_DONE   = 5'b01000,
    PH_FAILED = 5'b10000
  } phase_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_WAIT:   code = PH_CODE_WAIT;
      PH_SEND:   code = PH_CODE_SEND;
      PH_AWAIT:  code = PH_CODE_AWAIT;
      PH_DONE:   code = PH_CODE_DONE;
      PH_FAILED: code = PH_CODE_FAILED;
      default:   code = PH_CODE_WAIT;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

/* rtl/sdo_write_retry_sequencer_core.sv */
// Top level of the SDO write retry sequencer: tick processing and result register.
`default_nettype none

// One input transfer is one task tick and yields exactly one result transfer.
// The tick is evaluated combinationally between the sequencer state registers
// and the result register, so the block takes one tick per clock cycle while
// the result side is not stalling, with the result valid in the cycle after
// the input transfer, and a new tick is taken in the same cycle the pending result
// is taken. The sequencer waits until the data frame count changes, sends one
// expedited write request (command 0x2B), then waits for a 0x60 answer carrying
// the configured index and subindex under a one-shot timeout. Each timeout
// resends until max_retries resends were made; the next timeout enters the failed
// phase. In done and failed, a data timeout returns to waiting. The retry count
// is kept across a failure. Configuration writes are always taken (cfg_ready
// is tied high) and must only be issued while the block is idle.
module sdo_write_retry_sequencer_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input ticks
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // tdata, low bit up: data_rx_count[31:0], data_timeout[32],
  // answer_rx_count[64:33], answer_command[72:65], answer_index[88:73],
  // answer_subindex[96:89], zero pad[103:97]
  input  wire logic [sdo_wrs_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Results
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // tdata, low bit up: send_request[0], request_command[8:1],
  // out_index[24:9], out_subindex[32:25], out_data[64:33], sdo_failed[65],
  // phase_now[68:66], zero pad[71:69]
  output logic [sdo_wrs_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // Configuration writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sdo_wrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sdo_wrs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import sdo_wrs_pkg::*;

  // Unpack the input tick
  logic [31:0] data_rx_count;
  logic        data_timeout;
  logic [31:0] answer_rx_count;
  logic [7:0]  answer_command;
  logic [15:0] answer_index;
  logic [7:0]  answer_subindex;

  assign data_rx_count   = in_tdata[31:0];
  assign data_timeout    = in_tdata[32];
  assign answer_rx_count = in_tdata[64:33];
  assign answer_command  = in_tdata[72:65];
  assign answer_index    = in_tdata[88:73];
  assign answer_subindex = in_tdata[96:89];

  // Configuration registers
  logic [15:0] timeout_ticks_r;
  logic [3:0]  max_retries_r;
  logic [15:0] request_index_r;
  logic [7:0]  request_subindex_r;
  logic [31:0] request_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_ticks_r    <= RST_TIMEOUT_TICKS;
      max_retries_r      <= RST_MAX_RETRIES;
      request_index_r    <= RST_REQUEST_INDEX;
      request_subindex_r <= RST_REQUEST_SUBINDEX;
      request_data_r     <= RST_REQUEST_DATA;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TIMEOUT_TICKS:    timeout_ticks_r    <= cfg_data[15:0];
        REG_MAX_RETRIES:      max_retries_r      <= cfg_data[3:0];
        REG_REQUEST_INDEX:    request_index_r    <= cfg_data[15:0];
        REG_REQUEST_SUBINDEX: request_subindex_r <= cfg_data[7:0];
        REG_REQUEST_DATA:     request_data_r     <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Sequencer state
  phase_t      phase_r, phase_nxt;
  logic [3:0]  retry_count_r, retry_count_nxt;
  logic [15:0] timer_value_r, timer_value_nxt;
  logic        timer_running_r, timer_running_nxt;
  logic [31:0] last_data_count_r;
  logic [31:0] last_answer_count_r;

  // Result register
  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic in_xfer;
  logic send;
  logic failed;
  logic timer_event;
  logic answer_match;

  // Take a tick whenever the result register is free or being emptied
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // A fresh answer with the OK command for our object
  assign answer_match = (answer_rx_count != last_answer_count_r) &&
                        (answer_command == CMD_ANSWER_OK) &&
                        (answer_index == request_index_r) &&
                        (answer_subindex == request_subindex_r);

  always_comb begin
    phase_nxt         = phase_r;
    retry_count_nxt   = retry_count_r;
    timer_value_nxt   = timer_value_r;
    timer_running_nxt = timer_running_r;
    timer_event       = 1'b0;
    send              = 1'b0;
    failed            = 1'b0;

    // Advance the one-shot timer ahead of the phase logic
    if (timer_running_r) begin
      if (timer_value_r != TIMER_MAX) begin
        timer_value_nxt = timer_value_r + 16'd1;
      end
      if (timer_value_nxt >= timeout_ticks_r) begin
        timer_running_nxt = 1'b0;
        timer_event       = 1'b1;
      end
    end

    case (phase_r)
      PH_WAIT: begin
        if (data_rx_count != last_data_count_r) phase_nxt = PH_SEND;
      end
      PH_SEND: begin
        send      = 1'b1;
        phase_nxt = PH_AWAIT;
      end
      PH_AWAIT: begin
        // Arm the timer when idle and not firing this tick
        if (!timer_running_nxt && !timer_event) begin
          timer_running_nxt = 1'b1;
          timer_value_nxt   = 16'd0;
        end
        if (timer_event) begin
          if (retry_count_r >= max_retries_r) begin
            phase_nxt = PH_FAILED;
          end else begin
            phase_nxt       = PH_SEND;
            retry_count_nxt = retry_count_r + 4'd1;
          end
        end
        // A matching answer overrides the timeout decision
        if (answer_match) begin
          timer_running_nxt = 1'b0;
          timer_value_nxt   = 16'd0;
          retry_count_nxt   = 4'd0;
          phase_nxt         = PH_DONE;
        end
      end
      PH_DONE: begin
        if (data_timeout) phase_nxt = PH_WAIT;
      end
      PH_FAILED: begin
        failed = 1'b1;
        if (data_timeout) phase_nxt = PH_WAIT;
      end
      default: ;  // hold
    endcase

    out_tdata_nxt        = '0;
    out_tdata_nxt[0]     = send;
    out_tdata_nxt[8:1]   = CMD_WRITE_4;
    out_tdata_nxt[24:9]  = send ? request_index_r : 16'd0;
    out_tdata_nxt[32:25] = send ? request_subindex_r : 8'd0;
    out_tdata_nxt[64:33] = send ? request_data_r : 32'd0;
    out_tdata_nxt[65]    = failed;
    out_tdata_nxt[68:66] = phase_code(phase_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r             <= PH_WAIT;
      retry_count_r       <= 4'd0;
      timer_value_r       <= 16'd0;
      timer_running_r     <= 1'b0;
      last_data_count_r   <= 32'd0;
      last_answer_count_r <= 32'd0;
      out_tvalid_r        <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_r             <= phase_nxt;
        retry_count_r       <= retry_count_nxt;
        timer_value_r       <= timer_value_nxt;
        timer_running_r     <= timer_running_nxt;
        last_data_count_r   <= data_rx_count;
        last_answer_count_r <= answer_rx_count;
        out_tvalid_r        <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload register: load on every accepted tick, hold otherwise
  always_ff @(posedge clk) begin
    if (in_xfer) out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef NO_ASSERTIONS
  // Phase register stays one-hot
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase_r))
    else $error("phase register is not one-hot");

  // The answer timer only runs while awaiting the answer
  a_timer_in_await: assert property (@(posedge clk) disable iff (!rst_n)
    timer_running_r |-> (phase_r == PH_AWAIT))
    else $error("timer running outside the await phase");

  // A sent request always leaves the block awaiting the answer
  a_send_awaits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tdata_r[0]) |-> (out_tdata_r[68:66] == PH_CODE_AWAIT))
    else $error("request sent without entering the await phase");

  // Every accepted tick leaves a result pending
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_tvalid_r)
    else $error("accepted tick produced no result");
`endif

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the SDO write retry sequencer core: scoreboard, drivers and monitor.
module testbench;
  import sdo_wrs_pkg::*;

  // One task tick as it travels on the input stream
  typedef struct packed {
    logic [31:0] data_rx_count;
    logic        data_timeout;
    logic [31:0] answer_rx_count;
    logic [7:0]  answer_command;
    logic [15:0] answer_index;
    logic [7:0]  answer_subindex;
  } tick_item_t;

  // One result transfer: the request frame and the phase after the tick
  typedef struct packed {
    logic        send_request;
    logic [7:0]  request_command;
    logic [15:0] out_index;
    logic [7:0]  out_subindex;
    logic [31:0] out_data;
    logic        sdo_failed;
    logic [2:0]  phase_now;
  } tick_result_t;

  // Sequencer mirror: tracks registers and state, predicts one result per tick
  class sdo_tick_scoreboard;
    logic [15:0]  timeout_ticks;
    logic [3:0]   max_retries;
    logic [15:0]  req_index;
    logic [7:0]   req_subindex;
    logic [31:0]  req_data;
    logic [2:0]   phase;
    logic [3:0]   retry_count;
    logic [15:0]  timer_value;
    bit           timer_running;
    logic [31:0]  last_data_count;
    logic [31:0]  last_answer_count;
    tick_result_t frames_q[$];
    int           errors;

    function new();
      timeout_ticks     = RST_TIMEOUT_TICKS;
      max_retries       = RST_MAX_RETRIES;
      req_index         = RST_REQUEST_INDEX;
      req_subindex      = RST_REQUEST_SUBINDEX;
      req_data          = RST_REQUEST_DATA;
      phase             = PH_CODE_WAIT;
      retry_count       = '0;
      timer_value       = '0;
      timer_running     = 1'b0;
      last_data_count   = '0;
      last_answer_count = '0;
      errors            = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_TIMEOUT_TICKS:    timeout_ticks = val[15:0];
        REG_MAX_RETRIES:      max_retries   = val[3:0];
        REG_REQUEST_INDEX:    req_index     = val[15:0];
        REG_REQUEST_SUBINDEX: req_subindex  = val[7:0];
        REG_REQUEST_DATA:     req_data      = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return frames_q.size();
    endfunction

    // Advance the mirror by one tick and queue the frame it produces
    function void note_tick(tick_item_t it);
      tick_result_t r;
      bit fired;
      bit sent;
      bit failed;
      fired  = 1'b0;
      sent   = 1'b0;
      failed = 1'b0;
      // timer runs ahead of the phase logic and fires once
      if (timer_running) begin
        if (timer_value < TIMER_MAX) timer_value = timer_value + 16'd1;
        if (timer_value >= timeout_ticks) begin
          timer_running = 1'b0;
          fired = 1'b1;
        end
      end
      case (phase)
        PH_CODE_WAIT: begin
          if (it.data_rx_count != last_data_count) phase = PH_CODE_SEND;
        end
        PH_CODE_SEND: begin
          sent  = 1'b1;
          phase = PH_CODE_AWAIT;
        end
        PH_CODE_AWAIT: begin
          if (!timer_running && !fired) begin
            timer_running = 1'b1;
            timer_value   = '0;
          end
          if (fired) begin
            if (retry_count >= max_retries) begin
              phase = PH_CODE_FAILED;
            end else begin
              phase       = PH_CODE_SEND;
              retry_count = retry_count + 4'd1;
            end
          end
          // a matching answer overrides the timeout decision
          if (it.answer_rx_count != last_answer_count &&
              it.answer_command == CMD_ANSWER_OK &&
              it.answer_index == req_index && it.answer_subindex == req_subindex) begin
            timer_running = 1'b0;
            timer_value   = '0;
            retry_count   = '0;
            phase         = PH_CODE_DONE;
          end
        end
        PH_CODE_DONE: begin
          if (it.data_timeout) phase = PH_CODE_WAIT;
        end
        PH_CODE_FAILED: begin
          failed = 1'b1;
          if (it.data_timeout) phase = PH_CODE_WAIT;
        end
        default: ;
      endcase
      last_data_count   = it.data_rx_count;
      last_answer_count = it.answer_rx_count;

      r.send_request    = sent;
      r.request_command = CMD_WRITE_4;
      r.out_index       = sent ? req_index : 16'd0;
      r.out_subindex    = sent ? req_subindex : 8'd0;
      r.out_data        = sent ? req_data : 32'd0;
      r.sdo_failed      = failed;
      r.phase_now       = phase;
      frames_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] td);
      tick_result_t want;
      if (frames_q.size() == 0) begin
        report($sformatf("unexpected result 0x%0h", td));
      end else begin
        want = frames_q.pop_front();
        if (td[0] !== want.send_request)
          report($sformatf("send_request %0b, want %0b", td[0], want.send_request));
        if (td[8:1] !== want.request_command)
          report($sformatf("request_command 0x%0h, want 0x%0h", td[8:1],
                           want.request_command));
        if (td[24:9] !== want.out_index)
          report($sformatf("out_index 0x%0h, want 0x%0h", td[24:9], want.out_index));
        if (td[32:25] !== want.out_subindex)
          report($sformatf("out_subindex 0x%0h, want 0x%0h", td[32:25], want.out_subindex));
        if (td[64:33] !== want.out_data)
          report($sformatf("out_data 0x%0h, want 0x%0h", td[64:33], want.out_data));
        if (td[65] !== want.sdo_failed)
          report($sformatf("sdo_failed %0b, want %0b", td[65], want.sdo_failed));
        if (td[68:66] !== want.phase_now)
          report($sformatf("phase_now %0d, want %0d", td[68:66], want.phase_now));
        if (td[71:69] !== 3'b000)
          report($sformatf("pad bits 0x%0h not zero", td[71:69]));
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  cfg_idx_t               cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  sdo_tick_scoreboard sb = new();
  tick_item_t         prev_tick;   // last tick driven; random ticks evolve from it
  bit                 in_idle_on;  // allow gaps on the input side
  bit                 out_idle_on; // allow stalls on the result side

  sdo_write_retry_sequencer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Hard stop in case a handshake never completes
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Check every result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Stall the result side in random bursts while stalls are enabled
  initial begin : result_stall
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready = 1'b0;
      end else if (out_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Present one tick at a falling edge and hold it until the transfer
  task drive_tick(tick_item_t it);
    int gap;
    if (in_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {7'b0, it.answer_subindex, it.answer_index, it.answer_command,
                 it.answer_rx_count, it.data_timeout, it.data_rx_count};
    do @(posedge clk); while (!in_tready);
    sb.note_tick(it);
    prev_tick = it;
  endtask

  task tick(logic [31:0] dc, logic dto, logic [31:0] ac, logic [7:0] cmd,
            logic [15:0] idx, logic [7:0] sub);
    tick_item_t it;
    it.data_rx_count   = dc;
    it.data_timeout    = dto;
    it.answer_rx_count = ac;
    it.answer_command  = cmd;
    it.answer_index    = idx;
    it.answer_subindex = sub;
    drive_tick(it);
  endtask

  // Mostly well-formed traffic: occasional new data frames, answers that
  // usually match the configured object, and some pure noise
  function tick_item_t next_random_tick();
    tick_item_t it;
    it = prev_tick;
    it.data_timeout = ($urandom_range(0, 11) == 0);
    if ($urandom_range(0, 9) == 0) begin
      it.data_rx_count   = $urandom;
      it.data_timeout    = 1'($urandom_range(0, 1));
      it.answer_rx_count = $urandom;
      it.answer_command  = 8'($urandom_range(0, 255));
      it.answer_index    = 16'($urandom_range(0, 65535));
      it.answer_subindex = 8'($urandom_range(0, 255));
    end else begin
      if ($urandom_range(0, 9) == 0)
        it.data_rx_count = ($urandom_range(0, 3) == 0) ? $urandom
                                                       : prev_tick.data_rx_count + 32'd1;
      if ($urandom_range(0, 7) == 0) begin
        it.answer_rx_count = prev_tick.answer_rx_count + 32'd1;
        it.answer_command  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                         : CMD_ANSWER_OK;
        it.answer_index    = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                                         : sb.req_index;
        it.answer_subindex = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                         : sb.req_subindex;
      end
    end
    return it;
  endfunction

  // Hold off until every predicted frame has come out
  task drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task write_cfg(cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  // Write all five registers back to back, then drop the write valid
  task apply_settings(logic [15:0] tmo, logic [3:0] retries, logic [15:0] idx,
                      logic [7:0] sub, logic [31:0] data);
    write_cfg(REG_TIMEOUT_TICKS, {16'd0, tmo});
    write_cfg(REG_MAX_RETRIES, {28'd0, retries});
    write_cfg(REG_REQUEST_INDEX, {16'd0, idx});
    write_cfg(REG_REQUEST_SUBINDEX, {24'd0, sub});
    write_cfg(REG_REQUEST_DATA, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin : main
    int n_items;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_TIMEOUT_TICKS;
    cfg_data    = '0;
    prev_tick   = '0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: one clean request answered at the default object
    tick(32'h0, 1'b0, 32'h0, 8'h00, 16'h0000, 8'h00);
    tick(32'hFFFF_FFFF, 1'b0, 32'h0, 8'h00, 16'h0000, 8'h00);
    tick(32'hFFFF_FFFF, 1'b0, 32'h0, 8'h00, 16'h0000, 8'h00);
    tick(32'hFFFF_FFFF, 1'b0, 32'h0, 8'h00, 16'h0000, 8'h00);
    tick(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, CMD_ANSWER_OK, RST_REQUEST_INDEX,
         RST_REQUEST_SUBINDEX);
    tick(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, CMD_ANSWER_OK, RST_REQUEST_INDEX,
         RST_REQUEST_SUBINDEX);
    drain();

    // Shortest timeout, one resend: retry, fail, recover
    apply_settings(16'd1, 4'd1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    repeat (7) tick(32'h0, 1'b0, 32'hFFFF_FFFF, CMD_ANSWER_OK, 16'h6200, 8'h00);
    tick(32'h0, 1'b0, 32'hFFFF_FFFF, CMD_ANSWER_OK, 16'h6200, 8'h00);
    tick(32'h0, 1'b1, 32'hFFFF_FFFF, CMD_ANSWER_OK, 16'h6200, 8'h00);
    // retry count survives the failure, so the next timeout would fail at once
    tick(32'h1, 1'b0, 32'hFFFF_FFFF, CMD_ANSWER_OK, 16'h6200, 8'h00);
    tick(32'h1, 1'b0, 32'hFFFF_FFFF, CMD_ANSWER_OK, 16'h6200, 8'h00);
    // new answer with the wrong command starts nothing
    tick(32'h1, 1'b0, 32'h0, CMD_WRITE_4, 16'hFFFF, 8'hFF);
    // matching answer on the timeout tick wins
    tick(32'h1, 1'b0, 32'h1, CMD_ANSWER_OK, 16'hFFFF, 8'hFF);
    tick(32'h1, 1'b1, 32'h1, CMD_ANSWER_OK, 16'hFFFF, 8'hFF);
    // answers and data timeouts are ignored while waiting
    tick(32'h1, 1'b1, 32'h2, CMD_ANSWER_OK, 16'hFFFF, 8'hFF);
    drain();

    // Random phases, each under its own register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: apply_settings(16'd0, 4'd15, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        1: apply_settings(16'hFFFF, 4'd0, 16'h0000, 8'h00, 32'h0000_0000);
        default: apply_settings(16'($urandom_range(1, 6)),
                                ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 2))
                                                            : 4'($urandom_range(0, 15)),
                                16'($urandom_range(0, 65535)),
                                8'($urandom_range(0, 255)),
                                $urandom);
      endcase
      in_idle_on  = (ph != 7) && ($urandom_range(0, 3) != 0);
      out_idle_on = (ph != 7) && ($urandom_range(0, 3) != 0);
      n_items = (ph == 1) ? 40 : 100;
      repeat (n_items) drive_tick(next_random_tick());
      drain();
    end

    // Let any stray result surface before the verdict
    repeat (5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sdo_write_retry_sequencer_core.f */
rtl/sdo_wrs_pkg.sv
rtl/sdo_write_retry_sequencer_core.sv
bench/testbench.sv
